// ===== sv/gb3_pkg.sv =====
// ----------------------------------------------------------------------------
// gb3_pkg
// Shared types and constants of the 3x3 Gaussian blur block: result record,
// configuration register indexes and port widths.
// ----------------------------------------------------------------------------
package gb3_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

  // register reset values
  localparam int RST_IMAGE_WIDTH   = 640;
  localparam int RST_IMAGE_HEIGHT  = 480;
  localparam int RST_CHANNEL_COUNT = 3;

  // field widths
  localparam int SAMPLE_W = 8;
  localparam int OUT_X_W  = 11;
  localparam int ROW_W    = 16;
  localparam int CHAN_W   = 2;
  localparam int SUM_W    = 12;

  // one result transaction
  typedef struct packed {
    logic [SAMPLE_W-1:0] blurred;
    logic [OUT_X_W-1:0]  out_x;
    logic [ROW_W-1:0]    out_y;
    logic [CHAN_W-1:0]   out_channel;
    logic                frame_end;
  } result_t;

endpackage

// ===== sv/gaussian_blur_3x3.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_3x3
// 3x3 Gaussian blur (1 2 1 / 2 4 2 / 1 2 1, >> 4) over a raster stream of
// interleaved channel bytes, with frame-relative coordinates on each result.
// ----------------------------------------------------------------------------
// The block takes one sample per clock and keeps that rate indefinitely while
// the result side keeps up; a result is registered in the compute stage, then
// in the result buffer. Samples in the first two columns or rows give no
// result. The two rows above sit in one line memory (one read and one write
// per sample); the two previous columns of each channel sit in a small window
// memory that is read, shifted and written back per sample, with forwarding
// when consecutive samples hit the same channel. The line memory needs no
// clearing after reset: every frame writes two full rows before a row read
// back feeds a result. A configuration write restarts the frame counters.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3 #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [gb3_pkg::SAMPLE_W-1:0]        in_sample,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gb3_pkg::SAMPLE_W-1:0]        out_blurred,
  output logic [gb3_pkg::OUT_X_W-1:0]         out_x,
  output logic [gb3_pkg::ROW_W-1:0]           out_y,
  output logic [gb3_pkg::CHAN_W-1:0]          out_channel,
  output logic                                out_frame_end,
  // configuration port
  input  logic                                cfg_wr_en,
  input  logic [gb3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gb3_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import gb3_pkg::*;

  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int CW         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int AW         = XW + CW;
  localparam int LINE_DEPTH = MAX_WIDTH << CW;
  localparam int WEXT       = (XW + 1 > 12) ? XW + 1 : 12;
  localparam int WIN_W      = 6 * SAMPLE_W;
  localparam int RST_W_EFF  = (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;
  localparam int RST_C_EFF  = (RST_CHANNEL_COUNT > MAX_CHANNELS) ? MAX_CHANNELS
                                                                  : RST_CHANNEL_COUNT;

  // configuration: last valid index of each counter
  logic [XW-1:0]     w_last_r, w_last_nxt;
  logic [ROW_W-1:0]  h_last_r, h_last_nxt;
  logic [CHAN_W-1:0] nc_last_r, nc_last_nxt;
  logic [WEXT-1:0]   w_req;
  logic [WEXT-1:0]   w_eff;
  logic [2:0]        nc_req;
  logic [ROW_W-1:0]  h_req;

  // frame counters
  logic [XW-1:0]     cnt_x_r, cnt_x_nxt;
  logic [ROW_W-1:0]  cnt_y_r, cnt_y_nxt;
  logic [CHAN_W-1:0] cnt_c_r, cnt_c_nxt;

  // compute stage
  logic              s1_v_r;
  logic              s1_res_r;
  logic              s1_fe_r;
  logic              s1_fwd_r;
  logic [OUT_X_W-1:0] s1_x_r;
  logic [ROW_W-1:0]  s1_y_r;
  logic [CHAN_W-1:0] s1_c_r;
  logic [AW-1:0]     s1_addr_r;
  logic [SAMPLE_W-1:0] s1_sample_r;

  // memories
  logic [2*SAMPLE_W-1:0] line_mem [LINE_DEPTH];
  logic [2*SAMPLE_W-1:0] line_rd_r;
  logic [WIN_W-1:0]      win_mem [MAX_CHANNELS];
  logic [WIN_W-1:0]      win_rd_r;
  logic [WIN_W-1:0]      fwd_data_r;
  logic [WIN_W-1:0]      win_q;
  logic [WIN_W-1:0]      win_wdata;
  logic [AW-1:0]         line_addr;

  // datapath
  logic [SUM_W-1:0] row_top, row_mid, row_bot, sum;
  logic [SAMPLE_W-1:0] px_up, px_mid;
  logic             accept;
  logic             pop;
  logic [2:0]       occupancy;
  logic [1:0]       fifo_count;
  logic             fifo_push;
  result_t          res_in, res_out;

  assign accept    = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign line_addr = {cnt_x_r, cnt_c_r[CW-1:0]};

  // hold input while the compute stage plus the buffer would overflow
  assign occupancy = {1'b0, fifo_count} + {2'b00, s1_v_r};
  assign in_ready  = (occupancy - {2'b00, pop}) < 3'd2;

  // clamp configuration writes to the supported ranges
  always_comb begin
    w_last_nxt  = w_last_r;
    h_last_nxt  = h_last_r;
    nc_last_nxt = nc_last_r;
    w_req       = WEXT'(cfg_wdata[11:0]);
    h_req       = cfg_wdata[ROW_W-1:0];
    nc_req      = cfg_wdata[2:0];
    priority if (w_req < WEXT'(3)) begin
      w_eff = WEXT'(3);
    end else if (w_req > WEXT'(MAX_WIDTH)) begin
      w_eff = WEXT'(MAX_WIDTH);
    end else begin
      w_eff = w_req;
    end
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          w_last_nxt = XW'(w_eff - WEXT'(1));
        end
        CFG_IMAGE_HEIGHT: begin
          h_last_nxt = (h_req < ROW_W'(3)) ? ROW_W'(2) : h_req - ROW_W'(1);
        end
        CFG_CHANNEL_COUNT: begin
          priority if (nc_req == 3'd0) begin
            nc_last_nxt = '0;
          end else if (nc_req > 3'(MAX_CHANNELS)) begin
            nc_last_nxt = CHAN_W'(MAX_CHANNELS - 1);
          end else begin
            nc_last_nxt = CHAN_W'(nc_req - 3'd1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // advance raster counters; any register write restarts the frame
  always_comb begin
    cnt_x_nxt = cnt_x_r;
    cnt_y_nxt = cnt_y_r;
    cnt_c_nxt = cnt_c_r;
    priority if (cfg_wr_en && (cfg_index == CFG_IMAGE_WIDTH ||
                               cfg_index == CFG_IMAGE_HEIGHT ||
                               cfg_index == CFG_CHANNEL_COUNT)) begin
      cnt_x_nxt = '0;
      cnt_y_nxt = '0;
      cnt_c_nxt = '0;
    end else if (accept) begin
      if (cnt_c_r == nc_last_r) begin
        cnt_c_nxt = '0;
        if (cnt_x_r == w_last_r) begin
          cnt_x_nxt = '0;
          cnt_y_nxt = (cnt_y_r == h_last_r) ? '0 : cnt_y_r + ROW_W'(1);
        end else begin
          cnt_x_nxt = cnt_x_r + XW'(1);
        end
      end else begin
        cnt_c_nxt = cnt_c_r + CHAN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r  <= XW'(RST_W_EFF - 1);
      h_last_r  <= ROW_W'(RST_IMAGE_HEIGHT - 1);
      nc_last_r <= CHAN_W'(RST_C_EFF - 1);
      cnt_x_r   <= '0;
      cnt_y_r   <= '0;
      cnt_c_r   <= '0;
      s1_v_r    <= 1'b0;
      s1_fwd_r  <= 1'b0;
    end else begin
      w_last_r  <= w_last_nxt;
      h_last_r  <= h_last_nxt;
      nc_last_r <= nc_last_nxt;
      cnt_x_r   <= cnt_x_nxt;
      cnt_y_r   <= cnt_y_nxt;
      cnt_c_r   <= cnt_c_nxt;
      s1_v_r    <= accept;
      if (accept) begin
        s1_fwd_r <= s1_v_r && (s1_c_r == cnt_c_r);
      end
    end
  end

  // capture transaction context for the compute stage
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r    <= (cnt_x_r >= XW'(2)) && (cnt_y_r >= ROW_W'(2));
      s1_fe_r     <= (cnt_x_r == w_last_r) && (cnt_y_r == h_last_r) &&
                     (cnt_c_r == nc_last_r);
      s1_x_r      <= OUT_X_W'(cnt_x_r - XW'(1));
      s1_y_r      <= cnt_y_r - ROW_W'(1);
      s1_c_r      <= cnt_c_r;
      s1_addr_r   <= line_addr;
      s1_sample_r <= in_sample;
      fwd_data_r  <= win_wdata;
    end
  end

  // line memory: upper byte holds row y-2, lower byte row y-1
  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      line_mem[s1_addr_r] <= {line_rd_r[SAMPLE_W-1:0], s1_sample_r};
    end
    if (accept) begin
      line_rd_r <= line_mem[line_addr];
    end
  end

  // window memory: per channel, columns x-2 (low half) and x-1 (high half)
  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      win_mem[s1_c_r[CW-1:0]] <= win_wdata;
    end
    if (accept) begin
      win_rd_r <= win_mem[cnt_c_r[CW-1:0]];
    end
  end

  // forward the previous write when it hit the channel just read
  assign win_q  = s1_fwd_r ? fwd_data_r : win_rd_r;
  assign px_up  = line_rd_r[2*SAMPLE_W-1:SAMPLE_W];
  assign px_mid = line_rd_r[SAMPLE_W-1:0];

  // shift the window one column and insert the current column
  assign win_wdata = {s1_sample_r, px_mid, px_up, win_q[WIN_W-1:3*SAMPLE_W]};

  // weighted 3x3 sum
  always_comb begin
    row_top = SUM_W'(win_q[0*SAMPLE_W +: SAMPLE_W]) +
              (SUM_W'(win_q[3*SAMPLE_W +: SAMPLE_W]) << 1) + SUM_W'(px_up);
    row_mid = SUM_W'(win_q[1*SAMPLE_W +: SAMPLE_W]) +
              (SUM_W'(win_q[4*SAMPLE_W +: SAMPLE_W]) << 1) + SUM_W'(px_mid);
    row_bot = SUM_W'(win_q[2*SAMPLE_W +: SAMPLE_W]) +
              (SUM_W'(win_q[5*SAMPLE_W +: SAMPLE_W]) << 1) + SUM_W'(s1_sample_r);
    sum     = row_top + (row_mid << 1) + row_bot;
  end

  assign fifo_push           = s1_v_r && s1_res_r;
  assign res_in.blurred      = sum[SUM_W-1:4];
  assign res_in.out_x        = s1_x_r;
  assign res_in.out_y        = s1_y_r;
  assign res_in.out_channel  = s1_c_r;
  assign res_in.frame_end    = s1_fe_r;

  gb3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_data (res_in),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (res_out),
    .count     (fifo_count)
  );

  assign out_blurred   = res_out.blurred;
  assign out_x         = res_out.out_x;
  assign out_y         = res_out.out_y;
  assign out_channel   = res_out.out_channel;
  assign out_frame_end = res_out.frame_end;

`ifndef SYNTHESIS
  // compute stage and result buffer never hold more than two transactions
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= 3'd2)
    else $error("result buffer overflow");

  // counters stay inside the configured frame
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_c_r <= nc_last_r) && (cnt_x_r <= w_last_r) && (cnt_y_r <= h_last_r))
    else $error("frame counter out of range");

  // a forwarded window entry only follows a write to the same channel
  a_fwd_same_chan: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_fwd_r) |-> $past(s1_v_r) && (s1_c_r == $past(s1_c_r) ||
                                               !$past(accept)))
    else $error("window forwarding from a different channel");
`endif

endmodule

// ===== sv/gb3_out_fifo.sv =====
// ----------------------------------------------------------------------------
// gb3_out_fifo
// Two-entry result buffer between the compute stage and the result channel.
// Lets the compute stage finish every transaction without stalling.
// ----------------------------------------------------------------------------
module gb3_out_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gb3_pkg::result_t push_data,
  input  logic            out_ready,
  output logic            out_valid,
  output gb3_pkg::result_t out_data,
  output logic [1:0]      count
);
  import gb3_pkg::*;

  result_t    mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign out_data  = mem_r[rd_ptr_r];
  assign count     = count_r;
  assign pop       = out_valid && out_ready;

  // advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // store entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
